// ===== hdl/btpc_pkg.sv =====
// shared types, register codes and pipeline constants for the barometric compensation block
package btpc_pkg;

  // input request payload
  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_req_t;

  // result request payload
  typedef struct packed {
    logic signed [31:0] temp_centi_c;
    logic signed [31:0] fine_temp;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
  } out_req_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TEMP    = 2'd0,
    REG_PRES_LO = 2'd1,
    REG_PRES_HI = 2'd2,
    REG_P9      = 2'd3
  } cfg_reg_t;

  // one quotient bit per divider stage
  localparam int unsigned DIV_STEPS = 64;

  // total pipeline depth and side delay lines
  localparam int unsigned NSTG     = 88;
  localparam int unsigned TF_LEN   = 83;
  localparam int unsigned NZ_LEN   = 75;
  localparam int unsigned ADCP_LEN = 13;

  // offset added to the divisor polynomial, one shifted by 47
  localparam logic [63:0] Y1_BIAS = 64'h0000_8000_0000_0000;

  // sign extend a 16-bit coefficient to 64 bits
  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

// ===== hdl/btpc_if.sv =====
// valid/ready channel interfaces for input and result requests
interface btpc_in_if import btpc_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btpc_out_if import btpc_pkg::*; ();
  logic     valid;
  logic     ready;
  out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/btpc_mul64.sv =====
// two-stage multiplier giving the low 64 bits of a 64 by 64 product
module btpc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [63:0] lh;
  logic [63:0] hl;
  logic [63:0] pl_r;
  logic [31:0] pm_r;
  logic [63:0] p_r;

  // 32 by 32 partial products
  assign ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
  assign lh = {32'd0, a[31:0]} * {32'd0, b[63:32]};
  assign hl = {32'd0, a[63:32]} * {32'd0, b[31:0]};

  // register partials, then combine
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= ll;
      pm_r <= lh[31:0] + hl[31:0];
      p_r  <= pl_r + {pm_r, 32'd0};
    end
  end

  assign p = p_r;

endmodule

// ===== hdl/btpc_div64.sv =====
// pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero
module btpc_div64 import btpc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n,
  input  logic [63:0] d,
  output logic [63:0] q
);

  logic [63:0] rem_r [DIV_STEPS];
  logic [63:0] md_r  [DIV_STEPS];
  logic [63:0] nq_r  [DIV_STEPS+1];
  logic        neg_r [DIV_STEPS+1];
  logic [63:0] rem_nxt [DIV_STEPS];
  logic [63:0] nq_nxt  [DIV_STEPS];
  logic [64:0] sh      [DIV_STEPS];
  logic [64:0] trial   [DIV_STEPS];
  logic [63:0] q_r;

  // restoring step per stage
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      sh[k]    = {rem_r[k], nq_r[k][63]};
      trial[k] = sh[k] - {1'b0, md_r[k]};
      if (!trial[k][64]) begin
        rem_nxt[k] = trial[k][63:0];
        nq_nxt[k]  = {nq_r[k][62:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[k][63:0];
        nq_nxt[k]  = {nq_r[k][62:0], 1'b0};
      end
    end
  end

  // magnitudes in, stages, sign fix out
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= 64'd0;
      nq_r[0]  <= n[63] ? (64'd0 - n) : n;
      md_r[0]  <= d[63] ? (64'd0 - d) : d;
      neg_r[0] <= n[63] ^ d[63];
      for (int k = 0; k < DIV_STEPS; k++) begin
        nq_r[k+1]  <= nq_nxt[k];
        neg_r[k+1] <= neg_r[k];
      end
      for (int k = 1; k < DIV_STEPS; k++) begin
        rem_r[k] <= rem_nxt[k-1];
        md_r[k]  <= md_r[k-1];
      end
      q_r <= neg_r[DIV_STEPS] ? (64'd0 - nq_r[DIV_STEPS]) : nq_r[DIV_STEPS];
    end
  end

  assign q = q_r;

endmodule

// ===== hdl/baro_temp_pressure_compensation.sv =====
// top level: pipelined integer temperature and pressure compensation
//
//   channel  | direction | handshake    | payload
//   in_req   | in        | valid/ready  | raw_pressure, raw_temperature
//   out_res  | out       | valid/ready  | temp_centi_c, fine_temp, pressure_q24_8, pressure_valid
//   cfg      | in        | cfg_we       | cfg_idx, cfg_wdata
//
// one request per cycle while the pipeline is not held; results leave in request order
// the depth is set by the 64-stage divider plus chains of pipelined multipliers
// rst_n is synchronous; it empties the pipeline and clears the coefficients
// the whole pipeline holds while the output stage is full and out_res.ready is low
module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  btpc_in_if.sink           in_req,
  btpc_out_if.source        out_res,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [63:0]       cfg_wdata
);

  logic        en;
  logic [NSTG-1:0] vld_r;

  logic [47:0] cfg_temp_r;
  logic [63:0] cfg_plo_r;
  logic [63:0] cfg_phi_r;
  logic [15:0] cfg_p9_r;

  logic [15:0]        t1;
  logic signed [15:0] t2;
  logic signed [15:0] t3;

  logic [17:0]        a1_r;
  logic [16:0]        b1_r;
  logic [19:0]        adcp_d_r [ADCP_LEN];
  logic signed [33:0] m1_r;
  logic signed [33:0] bb_r;
  logic [31:0]        v1_3_r;
  logic signed [19:0] bs_r;
  logic signed [35:0] m3_r;
  logic [31:0]        v1_4_r;
  logic [31:0]        fine5_r;
  logic [31:0]        f5x;
  logic [31:0]        temp_nxt;
  logic [63:0]        tf_d_r [TF_LEN];
  logic [33:0]        x1_r;
  logic [63:0]        x1_64;

  logic [63:0] sq;
  logic [63:0] x1p5;
  logic [63:0] x1p2;
  logic [63:0] xp5_d_r [2];
  logic [63:0] xp2_d_r [2];
  logic [63:0] sqp6;
  logic [63:0] sqp3;
  logic [63:0] p4_sx;
  logic [63:0] x2_r;
  logic [63:0] y1a_r;
  logic [63:0] x2_d_r [2];
  logic [63:0] y1p;
  logic [63:0] y1_r;
  logic [NZ_LEN-1:0] nz_d_r;
  logic [20:0] padc;
  logic [63:0] num0_r;
  logic [63:0] num;
  logic [63:0] y1_d_r [2];
  logic [63:0] q;
  logic [63:0] ps;
  logic [63:0] psq;
  logic [63:0] p8p;
  logic [63:0] p_d_r [4];
  logic [63:0] c1p;
  logic [63:0] c2_d_r [2];
  logic [63:0] sum_r;
  logic [63:0] p7_sx;
  logic [63:0] pv;
  logic [31:0] pres_r;

  // global advance: output stage empty or being taken
  assign en           = !vld_r[NSTG-1] || out_res.ready;
  assign in_req.ready = en;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_temp_r <= '0;
      cfg_plo_r  <= '0;
      cfg_phi_r  <= '0;
      cfg_p9_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_TEMP:    cfg_temp_r <= cfg_wdata[47:0];
        REG_PRES_LO: cfg_plo_r  <= cfg_wdata;
        REG_PRES_HI: cfg_phi_r  <= cfg_wdata;
        REG_P9:      cfg_p9_r   <= cfg_wdata[15:0];
        default:     cfg_p9_r   <= cfg_p9_r;
      endcase
    end
  end

  assign t1 = cfg_temp_r[15:0];
  assign t2 = cfg_temp_r[31:16];
  assign t3 = cfg_temp_r[47:32];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_req.valid};
    end
  end

  // temperature stages
  assign f5x      = {fine5_r[29:0], 2'b00} + fine5_r + 32'd128;
  assign temp_nxt = {{8{f5x[31]}}, f5x[31:8]};

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= {1'b0, in_req.data.raw_temperature[19:3]} - {1'b0, t1, 1'b0};
      b1_r   <= {1'b0, in_req.data.raw_temperature[19:4]} - {1'b0, t1};
      m1_r   <= $signed(a1_r) * t2;
      bb_r   <= $signed(b1_r) * $signed(b1_r);
      v1_3_r <= {{11{m1_r[31]}}, m1_r[31:11]};
      bs_r   <= bb_r[31:12];
      m3_r   <= bs_r * t3;
      v1_4_r <= v1_3_r;
      fine5_r <= v1_4_r + {{14{m3_r[31]}}, m3_r[31:14]};
      x1_r   <= {{2{fine5_r[31]}}, fine5_r} - 34'd128000;
      tf_d_r[0] <= {temp_nxt, fine5_r};
      for (int i = 1; i < TF_LEN; i++) begin
        tf_d_r[i] <= tf_d_r[i-1];
      end
      adcp_d_r[0] <= in_req.data.raw_pressure;
      for (int i = 1; i < ADCP_LEN; i++) begin
        adcp_d_r[i] <= adcp_d_r[i-1];
      end
    end
  end

  assign x1_64 = {{30{x1_r[33]}}, x1_r};

  // first-order and square terms of the offset and the divisor
  btpc_mul64 u_sq   (.clk, .en, .a(x1_64), .b(x1_64), .p(sq));
  btpc_mul64 u_x1p5 (.clk, .en, .a(x1_64), .b(sx16(cfg_phi_r[15:0])), .p(x1p5));
  btpc_mul64 u_x1p2 (.clk, .en, .a(x1_64), .b(sx16(cfg_plo_r[31:16])), .p(x1p2));
  btpc_mul64 u_sqp6 (.clk, .en, .a(sq), .b(sx16(cfg_phi_r[31:16])), .p(sqp6));
  btpc_mul64 u_sqp3 (.clk, .en, .a(sq), .b(sx16(cfg_plo_r[47:32])), .p(sqp3));

  assign p4_sx = sx16(cfg_plo_r[63:48]);

  // offset and divisor sums
  always_ff @(posedge clk) begin
    if (en) begin
      xp5_d_r[0] <= x1p5;
      xp5_d_r[1] <= xp5_d_r[0];
      xp2_d_r[0] <= x1p2;
      xp2_d_r[1] <= xp2_d_r[0];
      x2_r  <= sqp6 + {xp5_d_r[1][46:0], 17'd0} + {p4_sx[28:0], 35'd0};
      y1a_r <= {{8{sqp3[63]}}, sqp3[63:8]} + {xp2_d_r[1][51:0], 12'd0} + Y1_BIAS;
      x2_d_r[0] <= x2_r;
      x2_d_r[1] <= x2_d_r[0];
    end
  end

  btpc_mul64 u_y1p (.clk, .en, .a(y1a_r), .b({48'd0, cfg_plo_r[15:0]}), .p(y1p));

  assign padc = 21'd1048576 - {1'b0, adcp_d_r[ADCP_LEN-1]};

  // divisor scale, zero check and numerator
  always_ff @(posedge clk) begin
    if (en) begin
      y1_r   <= {{33{y1p[63]}}, y1p[63:33]};
      num0_r <= {12'd0, padc, 31'd0} - x2_d_r[1];
      nz_d_r <= {nz_d_r[NZ_LEN-2:0], |y1p[63:33]};
      y1_d_r[0] <= y1_r;
      y1_d_r[1] <= y1_d_r[0];
    end
  end

  btpc_mul64 u_num (.clk, .en, .a(num0_r), .b(64'd3125), .p(num));
  btpc_div64 u_div (.clk, .en, .n(num), .d(y1_d_r[1]), .q(q));

  assign ps = {{13{q[63]}}, q[63:13]};

  // quadratic and linear corrections
  btpc_mul64 u_pss (.clk, .en, .a(ps), .b(ps), .p(psq));
  btpc_mul64 u_p8p (.clk, .en, .a(sx16(cfg_phi_r[63:48])), .b(q), .p(p8p));
  btpc_mul64 u_c1  (.clk, .en, .a(psq), .b(sx16(cfg_p9_r)), .p(c1p));

  assign p7_sx = sx16(cfg_phi_r[47:32]);
  assign pv    = {{8{sum_r[63]}}, sum_r[63:8]} + {p7_sx[59:0], 4'd0};

  // final sum and output register
  always_ff @(posedge clk) begin
    if (en) begin
      p_d_r[0] <= q;
      for (int i = 1; i < 4; i++) begin
        p_d_r[i] <= p_d_r[i-1];
      end
      c2_d_r[0] <= {{19{p8p[63]}}, p8p[63:19]};
      c2_d_r[1] <= c2_d_r[0];
      sum_r  <= p_d_r[3] + {{25{c1p[63]}}, c1p[63:25]} + c2_d_r[1];
      pres_r <= nz_d_r[NZ_LEN-2] ? pv[31:0] : 32'd0;
    end
  end

  assign out_res.valid               = vld_r[NSTG-1];
  assign out_res.data.temp_centi_c   = tf_d_r[TF_LEN-1][63:32];
  assign out_res.data.fine_temp      = tf_d_r[TF_LEN-1][31:0];
  assign out_res.data.pressure_q24_8 = pres_r;
  assign out_res.data.pressure_valid = nz_d_r[NZ_LEN-1];

endmodule

// ===== hdl/btpc_chk.sv =====
// port-level checker for the compensation top level, attached by bind
module btpc_chk import btpc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_req_t out_data
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a refused request is offered again
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("request withdrawn while stalled");

  // input is taken whenever the output side can move
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stage");

  // zero divisor forces pressure to zero
  a_zero_pres: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pressure_valid |-> out_data.pressure_q24_8 == 32'd0)
    else $error("pressure not cleared on zero divisor");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind baro_temp_pressure_compensation btpc_chk u_btpc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_data  (out_res.data)
);
